@@ sv/dq_pkg.sv @@
// Package for the double-ended queue: sizes, command and status codes.
package dq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [DATA_W-1:0]   data_t;
  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam cmd_t CMD_PUSH_FRONT = 3'd0;
  localparam cmd_t CMD_PUSH_BACK  = 3'd1;
  localparam cmd_t CMD_POP_FRONT  = 3'd2;
  localparam cmd_t CMD_POP_BACK   = 3'd3;
  localparam cmd_t CMD_LIST       = 3'd4;

  localparam status_t ST_DONE   = 2'd0;
  localparam status_t ST_LISTED = 2'd1;
  localparam status_t ST_EMPTY  = 2'd2;
  localparam status_t ST_FULL   = 2'd3;

endpackage

@@ sv/dq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/dq_addr.sv @@
// Shared ring position unit: (base + offset) modulo the queue depth.
module dq_addr (
  input  dq_pkg::idx_t base,
  input  dq_pkg::idx_t offset,
  output dq_pkg::idx_t pos
);
  import dq_pkg::*;

  logic [IDX_W:0] sum;
  logic [IDX_W:0] wrapped;

  // Both operands stay below the depth, so one compare and subtract wraps.
  always_comb begin
    sum     = {1'b0, base} + {1'b0, offset};
    wrapped = sum - (IDX_W + 1)'(QUEUE_DEPTH);
    if (sum >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
      pos = wrapped[IDX_W-1:0];
    end else begin
      pos = sum[IDX_W-1:0];
    end
  end

endmodule

@@ sv/double_ended_queue.sv @@
// Top level of the double-ended queue: command sequencer, ring state, result beats.
// Push, and any empty or full case: beat from the execute state; busy only in that state.
// Pop: the entry is read from the ring RAM; the result beat comes from the read state.
// List of N entries: one beat per entry, front to back (ring address, then RAM read).
// Results cannot be stalled; unknown commands are dropped with no beat and no busy.
// Reset (rst, synchronous) empties the queue; RAM contents are left as they are.
module double_ended_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  dq_pkg::cmd_t           command,
  input  logic signed [31:0]     push_value,
  output logic                   done,
  output logic signed [31:0]     item_value,
  output dq_pkg::status_t        status,
  output dq_pkg::cnt_t           entry_count,
  output logic                   last
);
  import dq_pkg::*;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // wait for a command
  localparam logic [1:0] S_EXEC = 2'd1;  // ring address, write or read issue
  localparam logic [1:0] S_READ = 2'd2;  // RAM data back, result beat

  logic [1:0] state, state_next;
  cmd_t       cmd;
  data_t      val;
  idx_t       front, front_next;
  cnt_t       count, count_next;
  idx_t       list_idx, list_idx_next;

  // Shared ring position unit
  idx_t addr_off;
  idx_t addr_pos;

  // RAM port
  logic  ram_we, ram_re;
  data_t ram_rdata;

  // Result beat staging
  logic    out_go;
  data_t   out_value;
  status_t out_status;
  cnt_t    out_count;
  logic    out_last;

  logic full, empty, list_end;

  assign busy     = (state != S_IDLE);
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign list_end = ((CNT_W'(list_idx) + CNT_W'(1)) == count);

  dq_addr u_addr (
    .base   (front),
    .offset (addr_off),
    .pos    (addr_pos)
  );

  dq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_pos),
    .wdata (val),
    .re    (ram_re),
    .raddr (addr_pos),
    .rdata (ram_rdata)
  );

  // Offset into the ring for the unit, by step and command.
  always_comb begin
    addr_off = '0;
    if (state == S_READ) begin
      // only pop front uses it here: front moves up by one
      addr_off = idx_t'(1);
    end else begin
      unique case (cmd) inside
        CMD_PUSH_FRONT: addr_off = idx_t'(QUEUE_DEPTH - 1);
        CMD_PUSH_BACK:  addr_off = count[IDX_W-1:0];
        CMD_POP_BACK:   addr_off = idx_t'(count - CNT_W'(1));
        CMD_LIST:       addr_off = list_idx;
        default:        addr_off = '0;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_next    = state;
    front_next    = front;
    count_next    = count;
    list_idx_next = list_idx;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    out_go        = 1'b0;
    out_value     = '0;
    out_status    = ST_DONE;
    out_count     = count;
    out_last      = 1'b1;

    unique case (state)
      S_IDLE: begin
        list_idx_next = '0;
        if (start && (command <= CMD_LIST)) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (cmd) inside
          CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            out_go     = 1'b1;
            state_next = S_IDLE;
            if (full) begin
              out_status = ST_FULL;
            end else begin
              ram_we     = 1'b1;
              count_next = count + CNT_W'(1);
              out_count  = count + CNT_W'(1);
              if (cmd == CMD_PUSH_FRONT) begin
                front_next = addr_pos;
              end
            end
          end
          CMD_POP_FRONT, CMD_POP_BACK: begin
            if (empty) begin
              out_go     = 1'b1;
              out_status = ST_EMPTY;
              state_next = S_IDLE;
            end else begin
              ram_re     = 1'b1;
              count_next = count - CNT_W'(1);
              state_next = S_READ;
            end
          end
          CMD_LIST: begin
            if (empty) begin
              out_go     = 1'b1;
              out_status = ST_EMPTY;
              state_next = S_IDLE;
            end else begin
              ram_re     = 1'b1;
              state_next = S_READ;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end

      S_READ: begin
        out_go    = 1'b1;
        out_value = ram_rdata;
        if (cmd == CMD_LIST) begin
          out_status = ST_LISTED;
          out_last   = list_end;
          if (list_end) begin
            state_next = S_IDLE;
          end else begin
            list_idx_next = list_idx + idx_t'(1);
            state_next    = S_EXEC;
          end
        end else begin
          // pop: count was already lowered, front moves for pop front
          if (cmd == CMD_POP_FRONT) begin
            front_next = addr_pos;
          end
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      front    <= '0;
      count    <= '0;
      list_idx <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      front    <= front_next;
      count    <= count_next;
      list_idx <= list_idx_next;
      done     <= out_go;
    end
  end

  // Command capture and result payload
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd <= command;
      val <= push_value;
    end
    if (out_go) begin
      item_value  <= out_value;
      status      <= out_status;
      entry_count <= out_count;
      last        <= out_last;
    end
  end

endmodule

@@ tb/double_ended_queue_tb.sv @@
// Self-checking testbench for the double-ended queue: directed cases, then random bursts.
module double_ended_queue_tb;
  import dq_pkg::*;

  // Reserved command codes: the block drops them with no beat and no busy.
  localparam cmd_t CMD_RSVD_5 = 3'd5;
  localparam cmd_t CMD_RSVD_6 = 3'd6;
  localparam cmd_t CMD_RSVD_7 = 3'd7;

  localparam data_t VAL_MIN  = 32'h8000_0000;
  localparam data_t VAL_MAX  = 32'h7FFF_FFFF;
  localparam data_t VAL_ZERO = 32'h0000_0000;
  localparam data_t VAL_NEG1 = 32'hFFFF_FFFF;

  // Cycles to let pass after the last beat.
  localparam int SETTLE_CYCLES = 10;
  // Cycles with neither an accepted command nor a result beat before giving up.
  // Worst correct case: the longest sender gap that pick_gap can draw.
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 120;

  // One expected result beat.
  typedef struct packed {
    data_t   value;
    status_t status;
    cnt_t    count;
    logic    last;
  } beat_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  cmd_t                command;
  logic signed [31:0]  push_value;
  logic                done;
  logic signed [31:0]  item_value;
  status_t             status;
  cnt_t                entry_count;
  logic                last;

  double_ended_queue DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .push_value  (push_value),
    .done        (done),
    .item_value  (item_value),
    .status      (status),
    .entry_count (entry_count),
    .last        (last)
  );

  // Shadow of the queue: ring store, front position and fill level.
  data_t ring_mem [QUEUE_DEPTH];
  int    ring_front;
  int    ring_count;

  // Beats the block still owes, oldest first.
  beat_t pending_beats[$];
  beat_t expected_beat;

  int fail_count;
  int commands_sent;
  int beats_checked;
  int full_drops;
  int empty_hits;
  int list_walks;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: applies one accepted command to the shadow queue and queues up
  // the beats it should produce. entry_count is always the level after the step.
  // ---------------------------------------------------------------------------
  task automatic add_beat(input data_t value, input status_t st, input logic is_last);
    beat_t b;
    b.value  = value;
    b.status = st;
    b.count  = cnt_t'(ring_count);
    b.last   = is_last;
    pending_beats.push_back(b);
  endtask

  task automatic apply_command(input cmd_t cmd, input data_t val);
    data_t popped;
    int    pos;
    case (cmd) inside
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (ring_count == QUEUE_DEPTH) begin
          // full: value dropped, state untouched
          full_drops++;
          add_beat(VAL_ZERO, ST_FULL, 1'b1);
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            ring_front = (ring_front + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
            ring_mem[ring_front] = val;
          end else begin
            ring_mem[(ring_front + ring_count) % QUEUE_DEPTH] = val;
          end
          ring_count++;
          add_beat(VAL_ZERO, ST_DONE, 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (ring_count == 0) begin
          empty_hits++;
          add_beat(VAL_ZERO, ST_EMPTY, 1'b1);
        end else begin
          if (cmd == CMD_POP_FRONT) begin
            popped     = ring_mem[ring_front];
            ring_front = (ring_front + 1) % QUEUE_DEPTH;
          end else begin
            popped = ring_mem[(ring_front + ring_count - 1) % QUEUE_DEPTH];
          end
          ring_count--;
          add_beat(popped, ST_DONE, 1'b1);
        end
      end
      CMD_LIST: begin
        list_walks++;
        if (ring_count == 0) begin
          empty_hits++;
          add_beat(VAL_ZERO, ST_EMPTY, 1'b1);
        end else begin
          // front to back, last marker on the final entry
          for (pos = 0; pos < ring_count; pos++)
            add_beat(ring_mem[(ring_front + pos) % QUEUE_DEPTH], ST_LISTED,
                     pos == ring_count - 1);
        end
      end
      default: ; // reserved codes: no beat, no state change
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender. Inputs move at the falling edge. start stays high from one command
  // into the next when there is no gap, so it is never dropped and re-raised in
  // the same step. A command is taken at the rising edge with start high and
  // busy low; busy is read before the edge updates land.
  // ---------------------------------------------------------------------------
  task automatic send_command(input cmd_t cmd, input data_t val, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start      = 1'b1;
    command    = cmd;
    push_value = val;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    commands_sent++;
    apply_command(cmd, val);
  endtask

  // Drop start and hold off until every owed beat has come, then let the
  // pipeline drain (a reserved command leaves nothing to wait for).
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random payload, with the corner values mixed in now and then.
  function automatic data_t pick_value();
    case ($urandom_range(0, 11))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return VAL_ZERO;
      3:       return VAL_NEG1;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobed beat must match the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat: item_value %0d status %0d entry_count %0d last %0b",
               item_value, status, entry_count, last);
        fail_count++;
      end else begin
        expected_beat = pending_beats.pop_front();
        beats_checked++;
        if (item_value !== expected_beat.value) begin
          $error("item_value: expected %0d, got %0d",
                 $signed(expected_beat.value), item_value);
          fail_count++;
        end
        if (status !== expected_beat.status) begin
          $error("status: expected %0d, got %0d", expected_beat.status, status);
          fail_count++;
        end
        if (entry_count !== expected_beat.count) begin
          $error("entry_count: expected %0d, got %0d", expected_beat.count, entry_count);
          fail_count++;
        end
        if (last !== expected_beat.last) begin
          $error("last: expected %0b, got %0b", expected_beat.last, last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any accepted command or result beat counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d beats still owed",
               STALL_LIMIT, pending_beats.size());
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pops and a list on an empty queue: each gives one empty beat.
  task automatic test_empty_queue();
    send_command(CMD_POP_FRONT, VAL_ZERO, 0);
    send_command(CMD_POP_BACK,  VAL_NEG1, 1);
    send_command(CMD_LIST,      VAL_ZERO, 0);
    wait_idle();
  endtask

  // Corner values through both ends; the first front push wraps the front
  // pointer below zero.
  task automatic test_value_extremes();
    send_command(CMD_PUSH_FRONT, VAL_MIN,  0);
    send_command(CMD_PUSH_BACK,  VAL_MAX,  0);
    send_command(CMD_PUSH_FRONT, VAL_ZERO, 2);
    send_command(CMD_PUSH_BACK,  VAL_NEG1, 0);
    send_command(CMD_LIST,       VAL_ZERO, 0);
    send_command(CMD_POP_FRONT,  VAL_ZERO, 0);
    send_command(CMD_POP_BACK,   VAL_ZERO, 1);
    send_command(CMD_POP_FRONT,  VAL_ZERO, 0);
    send_command(CMD_POP_BACK,   VAL_ZERO, 0);
    wait_idle();
  endtask

  // Reserved codes must leave the queue alone; the follow-up list proves it.
  task automatic test_reserved_commands();
    send_command(CMD_PUSH_BACK, pick_value(), 0);
    send_command(CMD_RSVD_5,    VAL_MAX,      0);
    send_command(CMD_RSVD_6,    VAL_NEG1,     0);
    send_command(CMD_RSVD_7,    VAL_MIN,      1);
    send_command(CMD_LIST,      VAL_ZERO,     0);
    send_command(CMD_POP_FRONT, VAL_ZERO,     0);
    wait_idle();
  endtask

  // Fill to the brim from both ends, bounce two pushes off the full queue,
  // list all entries, then drain past empty and list once more.
  task automatic test_full_ring();
    int n;
    for (n = 0; n < QUEUE_DEPTH; n++)
      send_command(n[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_value(), pick_gap(1'b0));
    send_command(CMD_PUSH_FRONT, pick_value(), 0);
    send_command(CMD_PUSH_BACK,  pick_value(), 0);
    send_command(CMD_LIST,       VAL_ZERO,     pick_gap(1'b0));
    for (n = 0; n <= QUEUE_DEPTH; n++)
      send_command(n[0] ? CMD_POP_FRONT : CMD_POP_BACK, pick_value(), pick_gap(1'b0));
    send_command(CMD_LIST, VAL_ZERO, 0);
    wait_idle();
  endtask

  // Bursts that lean toward filling, draining or neither, so the level sweeps
  // between empty and full. Some bursts run without gaps; some end by waiting until
  // every owed beat has come before the next one starts.
  task automatic test_random_bursts(input int target);
    int   sent;
    int   burst_left;
    int   mode;
    int   r;
    int   push_pct;
    int   pop_pct;
    bit   quiet;
    cmd_t cmd;
    sent       = 0;
    burst_left = 0;
    mode       = 0;
    quiet      = 1'b0;
    push_pct   = 50;
    pop_pct    = 35;
    while (sent < target) begin
      if (burst_left == 0) begin
        if (sent > 0 && $urandom_range(0, 2) == 0) wait_idle();
        burst_left = $urandom_range(10, 24);
        mode       = $urandom_range(0, 2);
        quiet      = ($urandom_range(0, 3) == 0);
        case (mode)
          0:       begin push_pct = 72; pop_pct = 18; end  // filling
          1:       begin push_pct = 18; pop_pct = 72; end  // draining
          default: begin push_pct = 42; pop_pct = 42; end
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < push_pct)
        cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      else if (r < push_pct + pop_pct)
        cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
      else if (r < 97)
        cmd = CMD_LIST;
      else
        case ($urandom_range(0, 2))
          0:       cmd = CMD_RSVD_5;
          1:       cmd = CMD_RSVD_6;
          default: cmd = CMD_RSVD_7;
        endcase
      send_command(cmd, pick_value(), pick_gap(quiet));
      // reserved codes are ignored by the block and do not count
      if (cmd <= CMD_LIST) sent++;
      burst_left--;
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    command       = CMD_PUSH_FRONT;
    push_value    = '0;
    ring_front    = 0;
    ring_count    = 0;
    fail_count    = 0;
    commands_sent = 0;
    beats_checked = 0;
    full_drops    = 0;
    empty_hits    = 0;
    list_walks    = 0;
    stall_cycles  = 0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_empty_queue();
    test_value_extremes();
    test_reserved_commands();
    test_full_ring();
    test_random_bursts(RANDOM_ITEMS);

    $display("run: %0d commands accepted, %0d result beats checked, %0d mismatches",
             commands_sent, beats_checked, fail_count);
    $display("covered: %0d full-queue push drops, %0d empty-queue beats, %0d list walks",
             full_drops, empty_hits, list_walks);
    if (fail_count == 0 && pending_beats.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/dq_pkg.sv
sv/dq_ram.sv
sv/dq_addr.sv
sv/double_ended_queue.sv
tb/double_ended_queue_tb.sv
